### src/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Input item: one byte of the scanned region.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } out_item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [63:0] pattern_lo;
    logic [63:0] pattern_hi;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
    logic [31:0] start_address;
    logic [31:0] result_offset;
  } cfg_t;

  // APB address: registers at 8-byte steps, six of them.
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LO     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HI     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_ADDRESS  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RESULT_OFFSET  = 3'd5;

  localparam logic [15:0] CARE_MASK_RESET      = 16'hFFFF;
  localparam logic [4:0]  PATTERN_LENGTH_RESET = 5'd1;

endpackage

### src/mbps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg
// APB register file: pattern, care mask, length, start address, offset.
// ----------------------------------------------------------------------------
module mbps_cfg import mbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_lo     <= '0;
      cfg_r.pattern_hi     <= '0;
      cfg_r.care_mask      <= CARE_MASK_RESET;
      cfg_r.pattern_length <= PATTERN_LENGTH_RESET;
      cfg_r.start_address  <= '0;
      cfg_r.result_offset  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PATTERN_LO:     cfg_r.pattern_lo     <= pwdata;
        REG_PATTERN_HI:     cfg_r.pattern_hi     <= pwdata;
        REG_CARE_MASK:      cfg_r.care_mask      <= pwdata[15:0];
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= pwdata[4:0];
        REG_START_ADDRESS:  cfg_r.start_address  <= pwdata[31:0];
        REG_RESULT_OFFSET:  cfg_r.result_offset  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LO:     prdata = cfg_r.pattern_lo;
      REG_PATTERN_HI:     prdata = cfg_r.pattern_hi;
      REG_CARE_MASK:      prdata = {48'd0, cfg_r.care_mask};
      REG_PATTERN_LENGTH: prdata = {59'd0, cfg_r.pattern_length};
      REG_START_ADDRESS:  prdata = {32'd0, cfg_r.start_address};
      REG_RESULT_OFFSET:  prdata = {32'd0, cfg_r.result_offset};
      default:            prdata = '0;
    endcase
  end

endmodule

### src/mbps_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the newest len window bytes against the pattern.
// ----------------------------------------------------------------------------
module mbps_match import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 16
) (
  input  logic [MAX_PATTERN-1:0][7:0] window,   // newest byte at top
  input  logic [127:0]                pattern,  // {pattern_hi, pattern_lo}
  input  logic [15:0]                 care,
  input  logic [4:0]                  len,      // already clamped 1..MAX
  output logic                        hit
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [5:0] pos;

  // Pattern byte i lines up with window byte MAX-len+i.
  always_comb begin
    hit = 1'b1;
    pos = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos = 6'(MAX_PATTERN) - {1'b0, len} + 6'(i);
      if ((6'(i) < {1'b0, len}) && care[i] &&
          (window[pos[IDX_W-1:0]] != pattern[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

### src/masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Scans a byte stream for the first masked match of a pattern of up to
// MAX_PATTERN bytes, reports its address or a miss, re-arms on the last byte.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                           Direction  Moves
//  -------  ------------------------------  ---------  -----------------------
//  in       in_valid/in_ready/in_data       sink       one byte + last flag
//  out      out_valid/out_ready/out_data    source     found + match address
//  cfg      psel/penable/pwrite/paddr/...   APB slave  64-bit registers at 8*i
//
//  One item per cycle while the skid register is empty. Each item is
//  compared in the cycle it is accepted and its result registered.
//  The output side has a main register and a skid register, so input keeps
//  flowing while one result waits; in_ready drops only when both are full.
//  Synchronous active-low reset clears window, byte count, match flag and
//  result buffer, and sets the registers to their reset values.
//
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 16    // window depth, 1..16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration (APB)
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // --------------------------------------------------------------------------
  // Scan state
  // --------------------------------------------------------------------------
  logic [MAX_PATTERN-1:0][7:0] win_r;       // win_r[MAX-1] is the newest byte
  logic [MAX_PATTERN-1:0][7:0] win_sh;
  logic [31:0]                 seen_r;      // bytes of this region so far, up to a match
  logic                        reported_r;  // match already given this region

  logic        acc;
  logic [4:0]  len;
  logic [31:0] seen_nxt;
  logic        enough;
  logic        win_hit;
  logic        match;
  logic [31:0] addr;
  logic        res_valid;
  out_item_t   res;

  assign acc = in_valid && in_ready;

  // Length 0 counts as 1; anything above the window depth saturates.
  always_comb begin
    priority if (cfg.pattern_length == 5'd0) begin
      len = 5'd1;
    end else if (cfg.pattern_length > 5'(MAX_PATTERN)) begin
      len = 5'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
  end

  // Window after the incoming byte is shifted in.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      win_sh[k] = win_r[k+1];
    end
    win_sh[MAX_PATTERN-1] = in_data.data_byte;
  end

  mbps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .window  (win_sh),
    .pattern ({cfg.pattern_hi, cfg.pattern_lo}),
    .care    (cfg.care_mask),
    .len     (len),
    .hit     (win_hit)
  );

  assign seen_nxt = seen_r + 32'd1;
  // seen_nxt >= len, with len below 32
  assign enough   = (|seen_nxt[31:5]) || (seen_nxt[4:0] >= len);
  assign match    = enough && win_hit;
  // start + position + offset, wraps mod 2^32
  assign addr     = cfg.start_address + (seen_nxt - {27'd0, len}) + cfg.result_offset;

  // A result comes from a match, or from the last byte of a region without one.
  // Once a match is reported the rest of the region is silent.
  assign res_valid         = acc && !reported_r && (match || in_data.last_byte);
  assign res.found         = match;
  assign res.match_address = match ? addr : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else if (acc) begin
      if (in_data.last_byte) begin
        // re-arm for the next region
        win_r      <= '0;
        seen_r     <= '0;
        reported_r <= 1'b0;
      end else if (!reported_r) begin
        win_r  <= win_sh;
        seen_r <= seen_nxt;
        if (match) begin
          reported_r <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: main register feeds the port, skid catches one more.
  // --------------------------------------------------------------------------
  logic      main_v_r;
  out_item_t main_d_r;
  logic      skid_v_r;
  out_item_t skid_d_r;
  logic      pop;

  assign pop       = main_v_r && out_ready;
  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      priority if (pop && skid_v_r) begin
        // skid moves up; a new result (only when in_ready) cannot arrive here
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else if (pop || !main_v_r) begin
        main_v_r <= res_valid;
      end else begin
        // main held: a new result parks in the skid
        skid_v_r <= skid_v_r || res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && skid_v_r) begin
      main_d_r <= skid_d_r;
    end else if (pop || !main_v_r) begin
      main_d_r <= res;
    end else begin
      if (res_valid) begin
        skid_d_r <= res;
      end
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked byte pattern search block. A queue of
// byte items, made of directed cases followed by random regions (most of them
// with the pattern planted), feeds a valid/ready driver. A behavioral scan
// model predicts every result as items are accepted. A monitor compares each
// result with the oldest prediction. Between phases the APB registers are
// rewritten while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import mbps_pkg::*;

  localparam int WIN          = 16;    // window depth of the block
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int LONG_HOLD    = 300;   // one long output back-pressure stretch
  localparam int DRAIN_CYCLES = 8;     // settle time after the last result
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 135;   // minimum bytes queued per random phase
  localparam int STRESS_PHASE = 5;     // one result per item, long hold-off
  localparam int STRESS_ITEMS = 150;
  localparam int MAX_REPORTS  = 30;

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  masked_byte_pattern_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t  pending_items[$];     // bytes waiting for the driver
  out_item_t expected_results[$];  // predicted results, oldest first
  out_item_t head_result;

  int  items_queued     = 0;
  int  items_accepted   = 0;
  int  results_checked  = 0;
  int  found_count      = 0;
  int  regions          = 0;
  int  settings_applied = 0;
  int  error_count      = 0;

  bit  in_taken      = 1'b0;  // item moved at the last rising edge
  bit  calm          = 1'b0;  // no idling on either side
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  send_gap  = 0;
  int  ready_gap = 0;
  int  hold_left = 0;

  // Scan model: its own copy of the registers, window, count and match flag.
  cfg_t live_cfg = '{pattern_lo: '0, pattern_hi: '0, care_mask: CARE_MASK_RESET,
                     pattern_length: PATTERN_LENGTH_RESET, start_address: '0,
                     result_offset: '0};
  logic [7:0]  window_bytes [WIN] = '{default: '0};
  logic [31:0] seen_count = '0;
  bit          match_seen = 1'b0;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------
  // Length 0 counts as 1; anything past the window depth saturates.
  function automatic int eff_len(input logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (raw > WIN) return WIN;
    return int'(raw);
  endfunction

  function automatic logic [7:0] pattern_byte(input int k);
    logic [127:0] both;
    both = {live_cfg.pattern_hi, live_cfg.pattern_lo};
    return both[8*k +: 8];
  endfunction

  function automatic void clear_window();
    int k;
    for (k = 0; k < WIN; k++) window_bytes[k] = '0;
    seen_count = '0;
    match_seen = 1'b0;
  endfunction

  // One accepted byte: shift, count, compare the newest len bytes.
  function automatic void scan_byte(input in_item_t it);
    int        len;
    int        k;
    bit        hit;
    bit        produced;
    out_item_t res;
    produced = 1'b0;
    if (!match_seen) begin
      for (k = 0; k < WIN - 1; k++) window_bytes[k] = window_bytes[k+1];
      window_bytes[WIN-1] = it.data_byte;
      seen_count = seen_count + 32'd1;
      len = eff_len(live_cfg.pattern_length);
      if (seen_count >= 32'(len)) begin
        hit = 1'b1;
        for (k = 0; k < len; k++)
          if (live_cfg.care_mask[k] && window_bytes[WIN-len+k] != pattern_byte(k))
            hit = 1'b0;
        if (hit) begin
          match_seen = 1'b1;
          res.found = 1'b1;
          res.match_address = live_cfg.start_address + (seen_count - 32'(len))
                              + live_cfg.result_offset;
          expected_results.push_back(res);
          produced = 1'b1;
        end
      end
      // region ended without a match
      if (it.last_byte && !produced) begin
        res = '0;
        expected_results.push_back(res);
      end
    end
    if (it.last_byte) clear_window();
  endfunction

  // --------------------------------------------------------------------------
  // Monitor and scoreboard: sample at the rising edge. Results are checked
  // before the accepted item is predicted; a result can never come out in
  // the same cycle its byte goes in.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: found=%0b addr=%h",
                                    out_data.found, out_data.match_address));
        end else begin
          head_result = expected_results.pop_front();
          results_checked++;
          if (head_result.found) found_count++;
          if (out_data.found !== head_result.found)
            report_mismatch($sformatf("found: expected %0b, got %0b",
                                      head_result.found, out_data.found));
          if (out_data.match_address !== head_result.match_address)
            report_mismatch($sformatf("match_address: expected %h, got %h",
                                      head_result.match_address,
                                      out_data.match_address));
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        items_accepted++;
        scan_byte(in_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input driver: moves on at the falling edge. Valid holds until the item
  // is taken; gaps come in random bursts, none once calm is set.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        send_gap <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: random stall bursts, plus one long hold-off on request so
  // the skid buffer fills and in_ready drops while items keep coming.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD - 1;
      out_ready      <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_gap <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no transfer of any kind happens for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("[masked_byte_pattern_search] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // APB write: setup, access, register lands at the edge with penable high.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LO:     live_cfg.pattern_lo     = value;
      REG_PATTERN_HI:     live_cfg.pattern_hi     = value;
      REG_CARE_MASK:      live_cfg.care_mask      = value[15:0];
      REG_PATTERN_LENGTH: live_cfg.pattern_length = value[4:0];
      REG_START_ADDRESS:  live_cfg.start_address  = value[31:0];
      REG_RESULT_OFFSET:  live_cfg.result_offset  = value[31:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_PATTERN_LO,     s.pattern_lo);
    write_reg(REG_PATTERN_HI,     s.pattern_hi);
    write_reg(REG_CARE_MASK,      64'(s.care_mask));
    write_reg(REG_PATTERN_LENGTH, 64'(s.pattern_length));
    write_reg(REG_START_ADDRESS,  64'(s.start_address));
    write_reg(REG_RESULT_OFFSET,  64'(s.result_offset));
    settings_applied++;
  endtask

  task automatic push_item(input logic [7:0] b, input bit last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Block idle: every queued byte taken, every result in, then a short
  // settle for a region whose last byte produced nothing.
  task automatic wait_idle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t r;
    r.pattern_lo = {$urandom, $urandom};
    r.pattern_hi = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       r.care_mask = 16'hFFFF;
      1:       r.care_mask = 16'h0000;
      default: r.care_mask = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       r.pattern_length = 5'd0;
      1:       r.pattern_length = 5'($urandom_range(17, 31));
      2:       r.pattern_length = 5'd16;
      default: r.pattern_length = 5'($urandom_range(1, 8));
    endcase
    r.start_address = $urandom;
    r.result_offset = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    return r;
  endfunction

  // One region: random bytes, usually with the pattern planted somewhere
  // (wildcard slots left random), sometimes spoiled by one flipped byte.
  task automatic add_region();
    logic [7:0] bytes_q[$];
    int len, span, at, k;
    bit plant;
    len  = eff_len(live_cfg.pattern_length);
    span = $urandom_range(1, len + 24);
    for (k = 0; k < span; k++) bytes_q.push_back(8'($urandom));
    plant = ($urandom_range(0, 9) != 0) && (span >= len);
    if (plant) begin
      at = $urandom_range(0, span - len);
      for (k = 0; k < len; k++)
        if (live_cfg.care_mask[k]) bytes_q[at+k] = pattern_byte(k);
      if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, len - 1);
        bytes_q[at+k] = bytes_q[at+k] ^ 8'($urandom_range(1, 255));
      end
    end
    for (k = 0; k < span; k++) push_item(bytes_q[k], k == span - 1);
    regions++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t s;
    int   p;
    int   k;
    int   start_count;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset registers: one-byte pattern 0x00, all bytes cared for.
    // A region with no match, then a match followed by an ignored last byte
    // that re-arms without a result.
    @(posedge clk);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hAA, 1'b1);
    regions += 2;
    wait_idle();

    // Four-byte pattern, address sum wraps past 2^32. Match ends on the last
    // byte (no found=0 after it); then a region too short to match.
    s = '{pattern_lo: 64'h0000_0000_EFBE_ADDE, pattern_hi: 64'h0,
          care_mask: 16'h000F, pattern_length: 5'd4,
          start_address: 32'hFFFF_FFF0, result_offset: 32'h0000_0020};
    apply_settings(s);
    @(posedge clk);
    push_item(8'h11, 1'b0);
    push_item(8'hDE, 1'b0);
    push_item(8'hAD, 1'b0);
    push_item(8'hBE, 1'b0);
    push_item(8'hEF, 1'b1);
    push_item(8'h01, 1'b0);
    push_item(8'h02, 1'b1);
    regions += 2;
    wait_idle();

    // Length zero behaves as one.
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    @(posedge clk);
    push_item(8'hDE, 1'b1);
    regions++;
    wait_idle();

    // Length above the window saturates to 16; only the end bytes cared for.
    s = '{pattern_lo: 64'hFFFF_FFFF_FFFF_FFFF, pattern_hi: 64'h00FF_FFFF_FFFF_FFFF,
          care_mask: 16'h8001, pattern_length: 5'd20,
          start_address: 32'h0, result_offset: 32'hFFFF_FFFF};
    apply_settings(s);
    @(posedge clk);
    push_item(8'hFF, 1'b0);
    for (k = 0; k < 14; k++) push_item(8'($urandom), 1'b0);
    push_item(8'h00, 1'b1);
    regions++;
    wait_idle();

    // Random phases, each with its own register settings. The first two
    // take the field extremes; the last two run without idling.
    for (p = 0; p < PHASES; p++) begin
      if (p == 0)
        s = '{pattern_lo: '1, pattern_hi: '1, care_mask: 16'hFFFF,
              pattern_length: 5'd31, start_address: 32'hFFFF_FFFF,
              result_offset: 32'hFFFF_FFFF};
      else if (p == 1)
        s = '{pattern_lo: '0, pattern_hi: '0, care_mask: 16'h0000,
              pattern_length: 5'd0, start_address: 32'h0, result_offset: 32'h0};
      else
        s = random_settings();
      apply_settings(s);
      @(posedge clk);
      if (p >= PHASES - 2) calm = 1'b1;
      if (p == STRESS_PHASE) begin
        // every item closes its region, so every item yields a result;
        // the long hold-off makes the block back up into the input
        long_hold_req = 1'b1;
        for (k = 0; k < STRESS_ITEMS; k++) push_item(8'($urandom), 1'b1);
        regions += STRESS_ITEMS;
      end else begin
        start_count = items_queued;
        while (items_queued - start_count < PHASE_ITEMS) add_region();
      end
      // sender waits here until every expected result is in
      wait_idle();
    end

    $display("Scanned %0d items in %0d regions under %0d register settings.",
             items_accepted, regions, settings_applied);
    $display("Checked %0d results (%0d matches), long hold-off done: %0b, mismatches: %0d.",
             results_checked, found_count, long_hold_done, error_count);
    if (error_count == 0) begin
      $display("[masked_byte_pattern_search] OK");
    end else begin
      $display("[masked_byte_pattern_search] ERROR");
    end
    $finish;
  end

endmodule

### masked_byte_pattern_search.f
src/mbps_pkg.sv
src/mbps_cfg.sv
src/mbps_match.sv
src/masked_byte_pattern_search.sv
tb/testbench.sv
